>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, character codes, command codes and field widths used by
// the console writer, which sizes its screen memory from them.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // Screen geometry
   localparam int COLS       = 80;
   localparam int ROWS       = 25;
   localparam int TAB_SPACES = 4;
   localparam int CELLS      = ROWS * COLS;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = CHAR_W + ATTR_W;
   localparam int RIDX_W  = 11;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int POS_W   = 11;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int TAB_W   = $clog2(TAB_SPACES + 1);

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Keeps a screen of character cells and a cursor; puts characters with
// backspace, newline, tab and wrap handling, scrolls, clears and reads cells.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  cmd, char_code, read_index
//   rsp_      out        rsp_valid/rsp_ready  cursor_col/row/pos, cell_value
//   csr_      in         csr_wr_en            csr_wr_data (attribute)
//
// Items do not overlap; an out-of-range read or unused command goes straight
// to the result. A put may wrap or scroll (one cell moved per cycle, then the
// bottom row filled); a clear fills every cell. An item is taken while a
// result still waits on rsp_ready, and the next result waits in the last
// state. Reset is synchronous; the screen memory holds garbage until cleared.
`default_nettype none

module text_console_writer (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [tcw_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [tcw_pkg::CHAR_W-1:0]   req_char_code,
   input  wire logic [tcw_pkg::RIDX_W-1:0]   req_read_index,

   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [tcw_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic      [tcw_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic      [tcw_pkg::POS_W-1:0]    rsp_cursor_pos,
   output logic      [tcw_pkg::CELL_W-1:0]   rsp_cell_value,

   input  wire logic                         csr_wr_en,
   input  wire logic [tcw_pkg::ATTR_W-1:0]   csr_wr_data
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_PRINT   = 9'b000000010,
      ST_NEWLINE = 9'b000000100,
      ST_BACK    = 9'b000001000,
      ST_BLANK   = 9'b000010000,
      ST_READ    = 9'b000100000,
      ST_SCROLL  = 9'b001000000,
      ST_FILL    = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   localparam logic [tcw_pkg::COL_W-1:0]  COL_FULL  = tcw_pkg::COL_W'(tcw_pkg::COLS);
   localparam logic [tcw_pkg::COL_W-1:0]  COL_LAST  = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
   localparam logic [tcw_pkg::ROW_W-1:0]  ROW_LAST  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
   localparam logic [tcw_pkg::ADDR_W-1:0] ADDR_LAST = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
   localparam logic [tcw_pkg::ADDR_W-1:0] MOVE_END  =
      tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS);
   localparam logic [tcw_pkg::ADDR_W-1:0] ROW_STEP  = tcw_pkg::ADDR_W'(tcw_pkg::COLS);
   localparam logic [tcw_pkg::RIDX_W-1:0] RIDX_END  = tcw_pkg::RIDX_W'(tcw_pkg::CELLS);
   localparam logic [tcw_pkg::TAB_W-1:0]  TAB_ONE   = tcw_pkg::TAB_W'(1);

   state_type                     state_ff, state_in;
   logic [tcw_pkg::COL_W-1:0]     col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [tcw_pkg::ATTR_W-1:0]    attr_ff, attr_in;
   logic [tcw_pkg::CHAR_W-1:0]    pchar_ff, pchar_in;
   logic [tcw_pkg::TAB_W-1:0]     tab_cnt_ff, tab_cnt_in;
   logic [tcw_pkg::ADDR_W-1:0]    scan_ff, scan_in;
   logic [tcw_pkg::ADDR_W-1:0]    wdst_ff, wdst_in;
   logic                          pend_ff, pend_in;
   logic [tcw_pkg::CELL_W-1:0]    cell_ff, cell_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::COL_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::ROW_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [tcw_pkg::CELL_W-1:0]    rsp_cell_ff, rsp_cell_in;

   logic                          accept;
   logic [tcw_pkg::POS_W-1:0]     cur_pos;
   logic [tcw_pkg::CELL_W-1:0]    space_cell;

   logic                          mem_we;
   logic [tcw_pkg::ADDR_W-1:0]    mem_waddr;
   logic [tcw_pkg::CELL_W-1:0]    mem_wdata;
   logic                          mem_re;
   logic [tcw_pkg::ADDR_W-1:0]    mem_raddr;
   logic [tcw_pkg::CELL_W-1:0]    mem_rdata;

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (tcw_pkg::CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign cur_pos    = tcw_pkg::POS_W'(row_ff) * tcw_pkg::POS_W'(tcw_pkg::COLS)
                     + tcw_pkg::POS_W'(col_ff);
   assign space_cell = {attr_ff, tcw_pkg::CH_SPACE};

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      attr_in      = csr_wr_en ? csr_wr_data : attr_ff;
      pchar_in     = pchar_ff;
      tab_cnt_in   = tab_cnt_ff;
      scan_in      = scan_ff;
      wdst_in      = wdst_ff;
      pend_in      = 1'b0;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cell_in  = rsp_cell_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_pos[tcw_pkg::ADDR_W-1:0];
      mem_wdata    = space_cell;
      mem_re       = 1'b0;
      mem_raddr    = req_read_index[tcw_pkg::ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cell_in    = '0;
               tab_cnt_in = '0;
               unique case (req_cmd)
                  tcw_pkg::CMD_PUT: begin
                     if (req_char_code == tcw_pkg::CH_BACKSPACE) begin
                        state_in = ST_BACK;
                     end else if (req_char_code == tcw_pkg::CH_NEWLINE) begin
                        state_in = ST_NEWLINE;
                     end else if (req_char_code == tcw_pkg::CH_TAB) begin
                        pchar_in   = tcw_pkg::CH_SPACE;
                        tab_cnt_in = tcw_pkg::TAB_W'(tcw_pkg::TAB_SPACES);
                        state_in   = ST_PRINT;
                     end else begin
                        pchar_in   = req_char_code;
                        tab_cnt_in = TAB_ONE;
                        state_in   = ST_PRINT;
                     end
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     scan_in  = '0;
                     state_in = ST_FILL;
                  end
                  tcw_pkg::CMD_READ: begin
                     if (req_read_index < RIDX_END) begin
                        mem_re   = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_PRINT: begin
            if (col_ff >= COL_FULL) begin
               // Full row: wrap first, scrolling when on the last row.
               col_in = '0;
               if (row_ff == ROW_LAST) begin
                  scan_in  = '0;
                  state_in = ST_SCROLL;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               mem_we     = 1'b1;
               mem_wdata  = {attr_ff, pchar_ff};
               col_in     = col_ff + 1'b1;
               tab_cnt_in = tab_cnt_ff - 1'b1;
               if (tab_cnt_ff == TAB_ONE) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_NEWLINE: begin
            col_in = '0;
            if (row_ff == ROW_LAST) begin
               scan_in  = '0;
               state_in = ST_SCROLL;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_BACK: begin
            if (col_ff != '0) begin
               col_in = col_ff - 1'b1;
            end else if (row_ff != '0) begin
               col_in = COL_LAST;
               row_in = row_ff - 1'b1;
            end
            state_in = ST_BLANK;
         end

         ST_BLANK: begin
            mem_we   = 1'b1;
            state_in = ST_DONE;
         end

         ST_READ: begin
            cell_in  = mem_rdata;
            state_in = ST_DONE;
         end

         ST_SCROLL: begin
            // Read one row below while writing the cell read last cycle.
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wdst_ff;
               mem_wdata = mem_rdata;
            end
            if (scan_ff != MOVE_END) begin
               mem_re    = 1'b1;
               mem_raddr = scan_ff + ROW_STEP;
               pend_in   = 1'b1;
               wdst_in   = scan_ff;
               scan_in   = scan_ff + 1'b1;
            end else begin
               state_in = ST_FILL;
            end
         end

         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == ADDR_LAST) begin
               state_in = (tab_cnt_ff != '0) ? ST_PRINT : ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = col_ff;
               rsp_row_in   = row_ff;
               rsp_pos_in   = cur_pos;
               rsp_cell_in  = cell_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         tab_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         tab_cnt_ff   <= tab_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pchar_ff    <= pchar_in;
      scan_ff     <= scan_in;
      wdst_ff     <= wdst_in;
      cell_ff     <= cell_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_value = rsp_cell_ff;

endmodule

`default_nettype wire
